>>> sv/sorted_string_fret_table_macros.svh
// assertion macros for the sorted string/fret table
// used by sorted_string_fret_table to check its own logic; no other dependencies
`ifndef SORTED_STRING_FRET_TABLE_MACROS_SVH
`define SORTED_STRING_FRET_TABLE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sst_pkg.sv
// shared types and constants for the sorted string/fret table
// no dependencies; imported by sst_cell and sorted_string_fret_table
package sst_pkg;

   localparam int MAX_NOTES = 8;
   localparam int KEY_W     = 4;
   localparam int FRET_W    = 8;
   localparam int CMD_W     = 2;
   localparam int CNT_W     = $clog2(MAX_NOTES + 1);
   localparam int OUT_CNT_W = 4;

   localparam logic [FRET_W-1:0] ABSENT_FRET = 8'd255;

   localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

   // update broadcast to every cell in the row
   typedef struct packed {
      logic              ins;
      logic              del;
      logic              upd;
      logic [KEY_W-1:0]  key;
      logic [FRET_W-1:0] fret;
   } sst_op_type;

endpackage

>>> sv/sst_cell.sv
// one slot of the sorted table: holds a string number and its fret
// depends on sst_pkg; chained left to right inside sorted_string_fret_table
module sst_cell
   import sst_pkg::*;
(
   input  logic              clock,
   input  sst_op_type        op,
   input  logic              occupied,
   input  logic              left_less,
   input  logic [KEY_W-1:0]  left_key,
   input  logic [FRET_W-1:0] left_fret,
   input  logic [KEY_W-1:0]  right_key,
   input  logic [FRET_W-1:0] right_fret,
   input  logic              hit_in,
   output logic              less,
   output logic              match,
   output logic              hit_out,
   output logic [KEY_W-1:0]  key,
   output logic [FRET_W-1:0] fret
);

   logic [KEY_W-1:0]  key_ff, key_in;
   logic [FRET_W-1:0] fret_ff, fret_in;

   assign less    = occupied && (key_ff < op.key);
   assign match   = occupied && (key_ff == op.key);
   assign hit_out = hit_in || match;
   assign key     = key_ff;
   assign fret    = fret_ff;

   always_comb begin
      key_in  = key_ff;
      fret_in = fret_ff;
      if (op.upd && match) begin
         fret_in = op.fret;
      end else if (op.ins && !less) begin
         // first cell not below the new key takes it, the rest shift right
         if (left_less) begin
            key_in  = op.key;
            fret_in = op.fret;
         end else begin
            key_in  = left_key;
            fret_in = left_fret;
         end
      end else if (op.del && hit_out) begin
         // everything from the removed slot on shifts left
         key_in  = right_key;
         fret_in = right_fret;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      fret_ff <= fret_in;
   end

endmodule

>>> sv/sorted_string_fret_table.sv
// Sorted string/fret table: up to MAX_NOTES notes kept in ascending string
// order in a row of cells, each cell holding one note and trading contents
// with its neighbors on insert (shift right) and delete (shift left). Every
// command (set, get, delete) completes at the accepting edge, where all
// cells compare the string number in parallel and update, so one beat
// per cycle is sustained while rsp_ready is high. The result is registered
// and appears the cycle after acceptance; a result not yet taken stalls
// req_ready. Unknown command codes change nothing and return 255.
module sorted_string_fret_table
   import sst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [KEY_W-1:0]     req_string_number,
   input  logic [FRET_W-1:0]    req_fret_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [FRET_W-1:0]    rsp_fret_out,
   output logic                 rsp_found,
   output logic                 rsp_paused,
   output logic                 rsp_table_full,
   output logic [OUT_CNT_W-1:0] rsp_entry_count
);

`include "sorted_string_fret_table_macros.svh"

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 pause_ff, pause_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FRET_W-1:0]    fret_out_ff, fret_out_in;
   logic                 found_ff, found_in;
   logic                 full_ff, full_in;

   logic                 req_fire;
   sst_op_type           op;
   logic [MAX_NOTES-1:0] occ, less_vec, match_vec;
   logic [MAX_NOTES:0]   hit_chain;
   logic [KEY_W-1:0]     cell_key  [MAX_NOTES];
   logic [FRET_W-1:0]    cell_fret [MAX_NOTES];
   logic [FRET_W-1:0]    hit_fret;
   logic                 found;
   logic                 is_full;
   logic                 do_ins, do_del, do_upd;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign found   = hit_chain[MAX_NOTES];
   assign is_full = (count_ff == CNT_W'(MAX_NOTES));
   assign do_upd  = (req_command == CMD_SET) && found;
   assign do_ins  = (req_command == CMD_SET) && !found && !is_full;
   assign do_del  = (req_command == CMD_DEL) && found;

   always_comb begin
      op.ins  = req_fire && do_ins;
      op.del  = req_fire && do_del;
      op.upd  = req_fire && do_upd;
      op.key  = req_string_number;
      op.fret = req_fret_value;
   end

   assign hit_chain[0] = 1'b0;

   genvar i;
   generate
      for (i = 0; i < MAX_NOTES; i++) begin : g_cell
         logic              l_less;
         logic [KEY_W-1:0]  l_key, r_key;
         logic [FRET_W-1:0] l_fret, r_fret;

         assign occ[i] = (CNT_W'(i) < count_ff);

         if (i == 0) begin : g_first
            assign l_less = 1'b1;
            assign l_key  = req_string_number;
            assign l_fret = req_fret_value;
         end else begin : g_mid
            assign l_less = less_vec[i-1];
            assign l_key  = cell_key[i-1];
            assign l_fret = cell_fret[i-1];
         end

         if (i == MAX_NOTES - 1) begin : g_last
            assign r_key  = cell_key[i];
            assign r_fret = cell_fret[i];
         end else begin : g_inner
            assign r_key  = cell_key[i+1];
            assign r_fret = cell_fret[i+1];
         end

         sst_cell u_cell (
            .clock      (clock),
            .op         (op),
            .occupied   (occ[i]),
            .left_less  (l_less),
            .left_key   (l_key),
            .left_fret  (l_fret),
            .right_key  (r_key),
            .right_fret (r_fret),
            .hit_in     (hit_chain[i]),
            .less       (less_vec[i]),
            .match      (match_vec[i]),
            .hit_out    (hit_chain[i+1]),
            .key        (cell_key[i]),
            .fret       (cell_fret[i])
         );
      end
   endgenerate

   // keys are unique, so at most one cell matches
   always_comb begin
      hit_fret = '0;
      for (int k = 0; k < MAX_NOTES; k++) begin
         hit_fret = hit_fret | (cell_fret[k] & {FRET_W{match_vec[k]}});
      end
   end

   always_comb begin
      count_in     = count_ff;
      pause_in     = pause_ff;
      rsp_valid_in = rsp_valid_ff;
      fret_out_in  = fret_out_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         fret_out_in  = ABSENT_FRET;
         found_in     = 1'b0;
         full_in      = 1'b0;
         case (req_command)
            CMD_SET: begin
               found_in = found;
               if (found) begin
                  fret_out_in = req_fret_value;
               end else if (is_full) begin
                  full_in = 1'b1;
               end else begin
                  fret_out_in = req_fret_value;
                  count_in    = count_ff + 1'b1;
                  if (count_ff == '0) begin
                     pause_in = 1'b0;
                  end
               end
            end
            CMD_GET: begin
               found_in = found;
               if (found) begin
                  fret_out_in = hit_fret;
               end
            end
            CMD_DEL: begin
               found_in = found;
               if (found) begin
                  fret_out_in = hit_fret;
                  count_in    = count_ff - 1'b1;
                  if (count_ff == CNT_W'(1)) begin
                     pause_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pause_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pause_ff     <= pause_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fret_out_ff <= fret_out_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fret_out    = fret_out_ff;
   assign rsp_found       = found_ff;
   assign rsp_paused      = pause_ff;
   assign rsp_table_full  = full_ff;
   assign rsp_entry_count = OUT_CNT_W'(count_ff);

   `SST_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(MAX_NOTES), "count above capacity")
   `SST_ASSERT_ALWAYS(a_pause_empty, pause_ff == (count_ff == '0), "paused flag out of step")
   `SST_ASSERT_ALWAYS(a_one_match, $onehot0(match_vec), "more than one cell matches")
   `SST_ASSERT_ALWAYS(a_full_miss, !(rsp_valid_ff && full_ff && found_ff), "full on a hit")
   `SST_ASSERT_NEXT(a_ins_count, op.ins, count_ff == $past(count_ff) + 1'b1, "insert lost")

endmodule
